### sv/tdlex_pkg.sv
package tdlex_pkg;

  localparam int NumStates  = 24;
  localparam int NumClasses = 16;
  localparam int NumKw      = 4;
  localparam int KwMaxLen   = 8;

  typedef logic [4:0] state_t;
  typedef logic [3:0] class_t;

  typedef enum logic [4:0] {
    TK_INICIO    = 5'd0,
    TK_FIN       = 5'd1,
    TK_LEER      = 5'd2,
    TK_ESCRIBIR  = 5'd3,
    TK_ID        = 5'd4,
    TK_CONST     = 5'd5,
    TK_LPAREN    = 5'd6,
    TK_RPAREN    = 5'd7,
    TK_SEMICOLON = 5'd8,
    TK_COMMA     = 5'd9,
    TK_ASSIGN    = 5'd10,
    TK_PLUS      = 5'd11,
    TK_MINUS     = 5'd12,
    TK_MUL       = 5'd13,
    TK_DIV       = 5'd14,
    TK_COMMENT   = 5'd15,
    TK_EOF       = 5'd16,
    TK_LEXERR    = 5'd17,
    TK_ASSIGNERR = 5'd18,
    TK_CONSTERR  = 5'd19
  } token_kind_t;

  // character classes
  localparam class_t CLS_LETTER  = 4'd0;
  localparam class_t CLS_DIGIT   = 4'd1;
  localparam class_t CLS_PLUS    = 4'd2;
  localparam class_t CLS_MINUS   = 4'd3;
  localparam class_t CLS_LPAREN  = 4'd4;
  localparam class_t CLS_RPAREN  = 4'd5;
  localparam class_t CLS_COMMA   = 4'd6;
  localparam class_t CLS_SEMI    = 4'd7;
  localparam class_t CLS_COLON   = 4'd8;
  localparam class_t CLS_EQUAL   = 4'd9;
  localparam class_t CLS_EOT     = 4'd10;
  localparam class_t CLS_SPACE   = 4'd11;
  localparam class_t CLS_OTHER   = 4'd12;
  localparam class_t CLS_STAR    = 4'd13;
  localparam class_t CLS_SLASH   = 4'd14;
  localparam class_t CLS_NEWLINE = 4'd15;

  // named scanner states
  localparam state_t ST_START        = 5'd0;
  localparam state_t ST_ID_DONE      = 5'd2;
  localparam state_t ST_EOF          = 5'd13;
  localparam state_t ST_COMMENT_BODY = 5'd19;
  localparam state_t ST_COMMENT_DONE = 5'd20;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam state_t NEXT_STATE [NumStates][NumClasses] = '{
    '{5'd1, 5'd3, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
      5'd11, 5'd14, 5'd13, 5'd0, 5'd14, 5'd16, 5'd17, 5'd0},
    '{5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
      5'd2, 5'd2, 5'd2, 5'd2, 5'd14, 5'd2, 5'd2, 5'd2},
    '{default: 5'd0},
    '{5'd22, 5'd3, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4,
      5'd4, 5'd4, 5'd4, 5'd4, 5'd22, 5'd4, 5'd4, 5'd4},
    '{default: 5'd0}, '{default: 5'd0}, '{default: 5'd0}, '{default: 5'd0},
    '{default: 5'd0}, '{default: 5'd0}, '{default: 5'd0},
    '{5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21,
      5'd21, 5'd12, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21, 5'd21},
    '{default: 5'd0}, '{default: 5'd0},
    '{5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
      5'd14, 5'd14, 5'd15, 5'd15, 5'd14, 5'd14, 5'd14, 5'd15},
    '{default: 5'd0}, '{default: 5'd0},
    '{5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18, 5'd18,
      5'd18, 5'd18, 5'd18, 5'd18, 5'd14, 5'd18, 5'd19, 5'd18},
    '{default: 5'd0},
    '{5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19,
      5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd19, 5'd20},
    '{default: 5'd0}, '{default: 5'd0},
    '{5'd22, 5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23,
      5'd23, 5'd23, 5'd23, 5'd23, 5'd22, 5'd23, 5'd23, 5'd23},
    '{default: 5'd0}
  };

  // token per state; entries of non-accepting states are unused
  localparam token_kind_t STATE_TOKEN [NumStates] = '{
    TK_INICIO, TK_INICIO, TK_ID, TK_INICIO, TK_CONST, TK_PLUS,
    TK_MINUS, TK_LPAREN, TK_RPAREN, TK_COMMA, TK_SEMICOLON, TK_INICIO,
    TK_ASSIGN, TK_EOF, TK_INICIO, TK_LEXERR, TK_MUL, TK_INICIO,
    TK_DIV, TK_INICIO, TK_COMMENT, TK_ASSIGNERR, TK_INICIO, TK_CONSTERR
  };

  localparam logic [NumStates-1:0] ACCEPT_MASK =
    (24'd1 << 2) | (24'd1 << 4) | (24'd1 << 5) | (24'd1 << 6) |
    (24'd1 << 7) | (24'd1 << 8) | (24'd1 << 9) | (24'd1 << 10) |
    (24'd1 << 12) | (24'd1 << 13) | (24'd1 << 15) | (24'd1 << 16) |
    (24'd1 << 18) | (24'd1 << 20) | (24'd1 << 21) | (24'd1 << 23);

  // tokens that leave their terminating character unconsumed
  localparam logic [NumStates-1:0] SENTINEL_MASK =
    (24'd1 << 2) | (24'd1 << 4) | (24'd1 << 15) |
    (24'd1 << 18) | (24'd1 << 20) | (24'd1 << 23);

  localparam logic [7:0] KW_TEXT [NumKw][KwMaxLen] = '{
    '{"i", "n", "i", "c", "i", "o", 8'h00, 8'h00},
    '{"f", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "s", "c", "r", "i", "b", "i", "r"}
  };
  localparam logic [3:0] KW_LEN [NumKw] = '{4'd6, 4'd3, 4'd4, 4'd8};

  typedef struct packed {
    logic        last;
    logic [15:0] line;
    logic [6:0]  len;
    token_kind_t kind;
  } token_t;

  typedef struct packed {
    state_t nx;
    logic   acc;
    logic   sent;
  } pass_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t cls;
    if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) begin
      cls = CLS_LETTER;
    end else if (c >= "0" && c <= "9") begin
      cls = CLS_DIGIT;
    end else begin
      unique case (c)
        "+":          cls = CLS_PLUS;
        "-":          cls = CLS_MINUS;
        "(":          cls = CLS_LPAREN;
        ")":          cls = CLS_RPAREN;
        ",":          cls = CLS_COMMA;
        ";":          cls = CLS_SEMI;
        ":":          cls = CLS_COLON;
        "=":          cls = CLS_EQUAL;
        CHAR_SPACE:   cls = CLS_SPACE;
        "*":          cls = CLS_STAR;
        "/":          cls = CLS_SLASH;
        CHAR_NEWLINE: cls = CLS_NEWLINE;
        default:      cls = CLS_OTHER;
      endcase
    end
    return cls;
  endfunction

  // one table step; end of text closes an open comment
  function automatic pass_t scan_pass(input state_t s, input class_t col, input logic eot);
    pass_t p;
    p.nx = NEXT_STATE[s][col];
    if (s == ST_COMMENT_BODY && eot) begin
      p.nx = ST_COMMENT_DONE;
    end
    p.acc  = ACCEPT_MASK[p.nx];
    p.sent = SENTINEL_MASK[p.nx] || (eot && p.acc && p.nx != ST_EOF);
    return p;
  endfunction

endpackage

### sv/table_driven_lexer_dfa.sv
// Table-driven lexical scanner.
// s_* channel: one character per request; s_tuser marks end of text, in
// which case s_tdata is ignored. cfg_* channel: writes drop_comments
// (1 drops comment tokens); always ready, write only while idle.
// m_* channel: tokens; tdata holds kind, lexeme length and line number,
// tlast marks the last token caused by one character.
// A token is registered into the output queue when its character is accepted.
// Throughput: one character per cycle while each yields at most one token and
// m_tready stays high; a character that yields two tokens queues both.
// The class lookup, the transition table and the keyword compare form a
// single combinational step between the scanner registers and a 3-entry
// token queue; s_tready is high while that queue holds at most one token,
// so a stalled receiver backs up the input after two queued tokens.
// After the eof token every further character gives one eof token.
// Reset (rst, synchronous) returns to the start state at line 1, empties
// the queue and sets drop_comments.
module table_driven_lexer_dfa #(
  parameter int LEXEME_MAX    = 127,
  parameter int KEYWORD_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tuser,   // [0] end_of_text
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [4:0] token_kind, [11:5] lexeme_length,
                                 // [27:12] line_number, [31:28] zero
  output logic        m_tlast    // last_of_run
);
  import tdlex_pkg::*;

  localparam int         KwW     = $clog2(KEYWORD_CHARS);
  localparam int         LenCapI = (LEXEME_MAX < 127) ? LEXEME_MAX : 127;
  localparam logic [6:0] LEN_CAP = 7'(LenCapI);
  localparam logic [6:0] KW_CAP  = 7'(KEYWORD_CHARS);
  localparam int         QDepth  = 3;

  state_t      scan_state, scan_state_next;
  logic [6:0]  lexeme_count, lexeme_count_next;
  logic [15:0] line_count, line_next;
  logic        past_end, past_end_next;
  logic        drop_comments;
  logic [7:0]  keyword_chars [KEYWORD_CHARS];

  logic        kw_we;
  logic [KwW-1:0] kw_addr;

  token_t      q [QDepth];
  token_t      q_next [QDepth];
  logic [1:0]  q_cnt, q_cnt_next, fill;

  logic        accept, pop;
  class_t      col;
  logic        is_blank, is_nl, consume1, consume2;
  logic [15:0] line_inc;
  logic [6:0]  cnt_inc, len1, len2;
  pass_t       p1, p2;
  token_kind_t kind1, kind2, kw_kind;
  logic        v0, v1, kw_match;
  token_t      e0, e1, tok_a, tok_b;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (q_cnt <= 2'd1);
  assign m_tvalid  = (q_cnt != 2'd0);
  assign pop       = m_tvalid && m_tready;
  assign m_tdata   = {4'b0000, q[0].line, q[0].len, q[0].kind};
  assign m_tlast   = q[0].last;

  always_comb begin
    kw_kind = TK_ID;
    for (int k = NumKw - 1; k >= 0; k--) begin
      kw_match = (lexeme_count == 7'(KW_LEN[k]));
      for (int i = 0; i < KwMaxLen; i++) begin
        if (i < int'(KW_LEN[k]) && keyword_chars[KwW'(i)] != KW_TEXT[k][i]) begin
          kw_match = 1'b0;
        end
      end
      if (kw_match) begin
        kw_kind = token_kind_t'(5'(k));
      end
    end
  end

  always_comb begin
    col      = s_tuser ? CLS_EOT : classify(s_tdata);
    is_nl    = !s_tuser && (s_tdata == CHAR_NEWLINE);
    is_blank = is_nl || (!s_tuser && (s_tdata == CHAR_SPACE));
    line_inc = (line_count != 16'hFFFF) ? line_count + 16'd1 : line_count;
    cnt_inc  = (lexeme_count < LEN_CAP) ? lexeme_count + 7'd1 : lexeme_count;
    p1       = scan_pass(scan_state, col, s_tuser);
    p2       = scan_pass(ST_START, col, s_tuser);
    consume1 = !p1.sent && !s_tuser;
    consume2 = !p2.sent && !s_tuser;
    len1     = consume1 ? cnt_inc : lexeme_count;
    len2     = consume2 ? 7'd1 : 7'd0;
    kind1    = (p1.nx == ST_ID_DONE) ? kw_kind : STATE_TOKEN[p1.nx];
    kind2    = STATE_TOKEN[p2.nx];

    scan_state_next   = scan_state;
    lexeme_count_next = lexeme_count;
    line_next         = line_count;
    past_end_next     = past_end;
    kw_we             = 1'b0;
    kw_addr           = lexeme_count[KwW-1:0];
    v0                = 1'b0;
    v1                = 1'b0;
    e0                = '{last: 1'b0, line: line_count, len: len1, kind: kind1};
    e1                = '{last: 1'b1, line: line_count, len: len2, kind: kind2};

    if (past_end) begin
      v0 = 1'b1;
      e0 = '{last: 1'b1, line: line_count, len: 7'd0, kind: TK_EOF};
    end else if (scan_state == ST_START && is_blank) begin
      if (is_nl) begin
        line_next = line_inc;
      end
    end else begin
      if (consume1 && lexeme_count < KW_CAP) begin
        kw_we = 1'b1;
      end
      if (!p1.acc) begin
        scan_state_next   = p1.nx;
        lexeme_count_next = len1;
      end else begin
        v0                = !(kind1 == TK_COMMENT && drop_comments);
        scan_state_next   = ST_START;
        lexeme_count_next = 7'd0;
        if (p1.nx == ST_EOF) begin
          past_end_next = 1'b1;
        end
        if (p1.sent) begin
          // rescan the terminating character from the start state
          if (is_blank) begin
            if (is_nl) begin
              line_next = line_inc;
            end
          end else begin
            if (consume2) begin
              kw_we   = 1'b1;
              kw_addr = '0;
            end
            if (!p2.acc) begin
              scan_state_next   = p2.nx;
              lexeme_count_next = len2;
            end else begin
              v1 = !(kind2 == TK_COMMENT && drop_comments);
              if (p2.nx == ST_EOF) begin
                past_end_next = 1'b1;
              end
            end
          end
        end
      end
    end
    e0.last = !v1;
  end

  always_comb begin
    tok_a = v0 ? e0 : e1;
    tok_b = e1;
    q_next = q;
    fill   = q_cnt;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
      fill      = q_cnt - 2'd1;
    end
    q_cnt_next = fill;
    if (accept) begin
      for (int i = 0; i < QDepth; i++) begin
        if ((v0 || v1) && int'(fill) == i) begin
          q_next[i] = tok_a;
        end
        if (v0 && v1 && int'(fill) + 1 == i) begin
          q_next[i] = tok_b;
        end
      end
      q_cnt_next = fill + 2'(v0) + 2'(v1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state    <= ST_START;
      lexeme_count  <= 7'd0;
      line_count    <= 16'd1;
      past_end      <= 1'b0;
      drop_comments <= 1'b1;
      q_cnt         <= 2'd0;
    end else begin
      if (accept) begin
        scan_state   <= scan_state_next;
        lexeme_count <= lexeme_count_next;
        line_count   <= line_next;
        past_end     <= past_end_next;
      end
      if (cfg_valid && cfg_ready) begin
        drop_comments <= cfg_data;
      end
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kw_we) begin
      keyword_chars[kw_addr] <= s_tdata;
    end
    q <= q_next;
  end

endmodule

### sv/tdlex_chk.sv
module tdlex_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // stalled token holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output token changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("token present right after reset");

  a_kind_line: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:0] <= 5'd19 && m_tdata[27:12] != 16'd0
                 && m_tdata[31:28] == 4'd0)
    else $error("bad token kind, line number or padding");

  // eof never carries characters
  a_eof_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:0] == 5'd16 |-> m_tdata[11:5] == 7'd0 && m_tlast)
    else $error("eof token with nonzero length or not last");

endmodule

bind table_driven_lexer_dfa tdlex_chk u_tdlex_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### dv/table_driven_lexer_dfa_tb.sv
module table_driven_lexer_dfa_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdlex_pkg::*;

  typedef enum logic [3:0] {
    C_LETTER, C_DIGIT, C_PLUS, C_MINUS, C_LPAREN, C_RPAREN, C_COMMA, C_SEMI,
    C_COLON, C_EQUAL, C_EOT, C_SPACE, C_OTHER, C_STAR, C_SLASH, C_NEWLINE
  } char_class_e;

  typedef enum logic [4:0] {
    S_START       = 5'd0,
    S_IDENT       = 5'd1,
    S_ID_END      = 5'd2,
    S_NUMBER      = 5'd3,
    S_NUM_END     = 5'd4,
    S_PLUS        = 5'd5,
    S_MINUS       = 5'd6,
    S_LPAREN      = 5'd7,
    S_RPAREN      = 5'd8,
    S_COMMA       = 5'd9,
    S_SEMI        = 5'd10,
    S_COLON       = 5'd11,
    S_ASSIGN      = 5'd12,
    S_EOF         = 5'd13,
    S_BAD         = 5'd14,
    S_BAD_END     = 5'd15,
    S_MUL         = 5'd16,
    S_SLASH       = 5'd17,
    S_DIV_END     = 5'd18,
    S_COMMENT     = 5'd19,
    S_COMMENT_END = 5'd20,
    S_ASSIGN_ERR  = 5'd21,
    S_BAD_NUM     = 5'd22,
    S_BAD_NUM_END = 5'd23
  } scan_state_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } char_req_t;

  typedef struct packed {
    token_kind_t kind;
    logic [6:0]  len;
    logic [15:0] line;
    logic        last;
  } lex_token_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'h00;
  logic        s_tuser   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  char_req_t   pending_chars [$];
  lex_token_t  tokens_due [$];
  char_req_t   next_req;
  lex_token_t  got_tok;
  lex_token_t  want_tok;
  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  // scanner shadow state
  scan_state_e scan_st  = S_START;
  logic [6:0]  lex_cnt  = 7'd0;
  logic [15:0] line_cnt = 16'd1;
  logic [7:0]  kw_buf [8] = '{default: 8'h00};
  logic        ended    = 1'b0;
  logic        drop_cfg = 1'b1;

  table_driven_lexer_dfa u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic char_class_e class_of(logic [7:0] c);
    if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) return C_LETTER;
    if (c >= 8'h30 && c <= 8'h39) return C_DIGIT;
    case (c)
      "+":   return C_PLUS;
      "-":   return C_MINUS;
      "(":   return C_LPAREN;
      ")":   return C_RPAREN;
      ",":   return C_COMMA;
      ";":   return C_SEMI;
      ":":   return C_COLON;
      "=":   return C_EQUAL;
      " ":   return C_SPACE;
      "*":   return C_STAR;
      "/":   return C_SLASH;
      8'h0A: return C_NEWLINE;
      default: return C_OTHER;
    endcase
  endfunction

  function automatic scan_state_e next_of(scan_state_e s, char_class_e c);
    case (s)
      S_START: begin
        case (c)
          C_LETTER: return S_IDENT;
          C_DIGIT:  return S_NUMBER;
          C_PLUS:   return S_PLUS;
          C_MINUS:  return S_MINUS;
          C_LPAREN: return S_LPAREN;
          C_RPAREN: return S_RPAREN;
          C_COMMA:  return S_COMMA;
          C_SEMI:   return S_SEMI;
          C_COLON:  return S_COLON;
          C_EQUAL:  return S_BAD;
          C_EOT:    return S_EOF;
          C_OTHER:  return S_BAD;
          C_STAR:   return S_MUL;
          C_SLASH:  return S_SLASH;
          default:  return S_START;
        endcase
      end
      S_IDENT: begin
        if (c == C_LETTER || c == C_DIGIT) return S_IDENT;
        if (c == C_OTHER) return S_BAD;
        return S_ID_END;
      end
      S_NUMBER: begin
        if (c == C_DIGIT) return S_NUMBER;
        if (c == C_LETTER || c == C_OTHER) return S_BAD_NUM;
        return S_NUM_END;
      end
      S_COLON: return (c == C_EQUAL) ? S_ASSIGN : S_ASSIGN_ERR;
      S_BAD: begin
        if (c == C_EOT || c == C_SPACE || c == C_NEWLINE) return S_BAD_END;
        return S_BAD;
      end
      S_SLASH: begin
        if (c == C_OTHER) return S_BAD;
        if (c == C_SLASH) return S_COMMENT;
        return S_DIV_END;
      end
      // end of text closes an open comment
      S_COMMENT: return (c == C_NEWLINE || c == C_EOT) ? S_COMMENT_END : S_COMMENT;
      S_BAD_NUM: begin
        if (c == C_LETTER || c == C_DIGIT || c == C_OTHER) return S_BAD_NUM;
        return S_BAD_NUM_END;
      end
      default: return S_START;
    endcase
  endfunction

  function automatic logic accepting(scan_state_e s);
    case (s)
      S_ID_END, S_NUM_END, S_PLUS, S_MINUS, S_LPAREN, S_RPAREN, S_COMMA, S_SEMI,
      S_ASSIGN, S_EOF, S_BAD_END, S_MUL, S_DIV_END, S_COMMENT_END, S_ASSIGN_ERR,
      S_BAD_NUM_END: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // tokens that leave their terminating character for a rescan
  function automatic logic needs_lookahead(scan_state_e s);
    case (s)
      S_ID_END, S_NUM_END, S_BAD_END, S_DIV_END, S_COMMENT_END,
      S_BAD_NUM_END: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic token_kind_t token_of(scan_state_e s);
    case (s)
      S_NUM_END:     return TK_CONST;
      S_PLUS:        return TK_PLUS;
      S_MINUS:       return TK_MINUS;
      S_LPAREN:      return TK_LPAREN;
      S_RPAREN:      return TK_RPAREN;
      S_COMMA:       return TK_COMMA;
      S_SEMI:        return TK_SEMICOLON;
      S_ASSIGN:      return TK_ASSIGN;
      S_EOF:         return TK_EOF;
      S_BAD_END:     return TK_LEXERR;
      S_MUL:         return TK_MUL;
      S_DIV_END:     return TK_DIV;
      S_COMMENT_END: return TK_COMMENT;
      S_ASSIGN_ERR:  return TK_ASSIGNERR;
      S_BAD_NUM_END: return TK_CONSTERR;
      default:       return TK_ID;
    endcase
  endfunction

  function automatic logic lexeme_spells(string w);
    if (lex_cnt != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++) begin
      if (kw_buf[i] != w[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic token_kind_t word_kind();
    if (lexeme_spells("inicio")) return TK_INICIO;
    if (lexeme_spells("fin")) return TK_FIN;
    if (lexeme_spells("leer")) return TK_LEER;
    if (lexeme_spells("escribir")) return TK_ESCRIBIR;
    return TK_ID;
  endfunction

  // advance the shadow scanner by one character, queue the tokens it yields
  function automatic void scan_char(logic [7:0] c, logic eot);
    char_class_e cls;
    scan_state_e nx;
    logic        rescan;
    lex_token_t  toks [2];
    int          n;
    cls = eot ? C_EOT : class_of(c);
    n = 0;
    if (ended) begin
      toks[0].kind = TK_EOF;
      toks[0].len  = 7'd0;
      toks[0].line = line_cnt;
      toks[0].last = 1'b1;
      tokens_due.push_back(toks[0]);
      return;
    end
    for (int pass = 0; pass < 2; pass++) begin
      if (scan_st == S_START && (cls == C_SPACE || cls == C_NEWLINE)) begin
        if (cls == C_NEWLINE && line_cnt != 16'hFFFF) line_cnt = line_cnt + 16'd1;
        break;
      end
      nx = next_of(scan_st, cls);
      rescan = needs_lookahead(nx) || (eot && accepting(nx) && nx != S_EOF);
      if (!rescan && !eot) begin
        if (lex_cnt < 7'd8) kw_buf[lex_cnt[2:0]] = c;
        if (lex_cnt < 7'd127) lex_cnt = lex_cnt + 7'd1;
      end
      if (!accepting(nx)) begin
        scan_st = nx;
        break;
      end
      toks[n].kind = (nx == S_ID_END) ? word_kind() : token_of(nx);
      toks[n].len  = lex_cnt;
      toks[n].line = line_cnt;
      toks[n].last = 1'b0;
      if (!(toks[n].kind == TK_COMMENT && drop_cfg)) n++;
      scan_st = S_START;
      lex_cnt = 7'd0;
      if (nx == S_EOF) ended = 1'b1;
      if (!rescan) break;
    end
    if (n > 0) toks[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) tokens_due.push_back(toks[i]);
  endfunction

  // character driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 8'h00;
      s_tuser  <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) scan_char(s_tdata, s_tuser);
      if (!s_tvalid || s_tready) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_chars.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= next_req.ch;
          s_tuser  <= next_req.eot;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // token monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        got_tok.kind = token_kind_t'(m_tdata[4:0]);
        got_tok.len  = m_tdata[11:5];
        got_tok.line = m_tdata[27:12];
        got_tok.last = m_tlast;
        if (tokens_due.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected token: kind %0d len %0d line %0d last %0b",
                     got_tok.kind, got_tok.len, got_tok.line, got_tok.last);
          mismatches++;
        end else begin
          want_tok = tokens_due.pop_front();
          if (got_tok.kind !== want_tok.kind || got_tok.len !== want_tok.len ||
              got_tok.line !== want_tok.line || got_tok.last !== want_tok.last ||
              m_tdata[31:28] !== 4'd0) begin
            if (mismatches < 10) begin
              $write("token mismatch: expected kind %0d len %0d line %0d last %0b, ",
                     want_tok.kind, want_tok.len, want_tok.line, want_tok.last);
              $display("got kind %0d len %0d line %0d last %0b (tdata %h)",
                       got_tok.kind, got_tok.len, got_tok.line, got_tok.last, m_tdata);
            end
            mismatches++;
          end
        end
      end
    end
  end

  task automatic push_ch(logic [7:0] c);
    char_req_t r;
    r.ch  = c;
    r.eot = 1'b0;
    pending_chars.push_back(r);
  endtask

  task automatic push_eot(logic [7:0] c, logic eot);
    char_req_t r;
    r.ch  = c;
    r.eot = eot;
    pending_chars.push_back(r);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'($urandom_range(8'h7A, 8'h61))
                             : 8'($urandom_range(8'h5A, 8'h41));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'($urandom_range(8'h39, 8'h30));
  endfunction

  function automatic logic [7:0] rand_body_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == 8'h0A);
    return b;
  endfunction

  function automatic string keyword_text(int k);
    case (k)
      0: return "inicio";
      1: return "fin";
      2: return "leer";
      default: return "escribir";
    endcase
  endfunction

  task automatic push_ident(int len);
    push_ch(rand_letter());
    repeat (len - 1) push_ch($urandom_range(2) == 0 ? rand_digit() : rand_letter());
  endtask

  task automatic push_number(int len);
    repeat (len) push_ch(rand_digit());
  endtask

  task automatic add_random_lexeme();
    int    pick;
    int    len;
    string kw;
    string ops;
    pick = $urandom_range(99);
    ops  = "+-(),;*/=";
    if (pick < 12) begin
      push_text(keyword_text($urandom_range(3)));
    end else if (pick < 26) begin
      len = ($urandom_range(49) == 0) ? $urandom_range(140, 120) : $urandom_range(10, 1);
      push_ident(len);
    end else if (pick < 36) begin
      len = ($urandom_range(49) == 0) ? $urandom_range(135, 125) : $urandom_range(6, 1);
      push_number(len);
    end else if (pick < 54) begin
      len = $urandom_range(ops.len());
      if (len == ops.len()) push_text(":=");
      else push_ch(ops[len]);
    end else if (pick < 62) begin
      push_text("//");
      len = ($urandom_range(19) == 0) ? $urandom_range(140, 125) : $urandom_range(12);
      repeat (len) push_ch(rand_body_char());
      push_ch(8'h0A);
    end else if (pick < 68) begin
      kw = keyword_text($urandom_range(3));
      case ($urandom_range(2))
        0: push_text(kw.substr(0, kw.len() - 2));
        1: begin
          push_text(kw);
          push_ch(rand_letter());
        end
        default: begin
          push_ch(kw[0] - 8'd32);
          push_text(kw.substr(1, kw.len() - 1));
        end
      endcase
    end else if (pick < 78) begin
      push_ch(8'($urandom_range(255)));
    end else if (pick < 84) begin
      case ($urandom_range(2))
        0: begin
          push_ch(":");
          push_ch(8'($urandom_range(255)));
        end
        1: begin
          push_number($urandom_range(3, 1));
          push_ident($urandom_range(3, 1));
        end
        default: begin
          push_ident($urandom_range(3, 1));
          push_ch(8'($urandom_range(255, 128)));
        end
      endcase
    end else begin
      repeat ($urandom_range(3, 1)) push_ch($urandom_range(3) == 0 ? 8'h0A : 8'h20);
    end
    if ($urandom_range(1)) push_ch($urandom_range(3) == 0 ? 8'h0A : 8'h20);
  endtask

  task automatic add_random_text(int count);
    while (pending_chars.size() < count) add_random_lexeme();
  endtask

  // leaves a lexeme open (or not) for the end-of-text request
  task automatic add_open_tail();
    case ($urandom_range(8))
      0: push_text("//ab");
      1: push_text(":");
      2: push_text("abc");
      3: push_text("12");
      4: push_text("a$");
      5: push_text("1a");
      6: push_text("/");
      7: push_text("fin");
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_chars.size() > 0 || s_tvalid || tokens_due.size() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_drop(logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    drop_cfg = v;
    @(negedge clk);
  endtask

  task automatic set_idle(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pass with comments dropped, as after reset
    set_idle(28, 71);
    push_text("fin(a1,2);:=+-*/9z:?");
    push_ch(8'hFF);
    push_ch(8'h00);
    push_text("\n//c\n");
    wait_drained();

    write_drop(1'b0);
    add_random_text(480);
    wait_drained();

    write_drop(1'b1);
    set_idle(71, 28);
    add_random_text(480);
    wait_drained();

    write_drop(1'b0);
    set_idle(0, 0);
    add_random_text(480);
    push_text("x;\n");
    add_open_tail();
    push_eot(8'($urandom_range(255)), 1'b1);
    repeat (20) push_eot(8'($urandom_range(255)), 1'($urandom_range(1)));
    wait_drained();
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #7_200_000;
    $display("Verification failed");
    $finish;
  end

endmodule

### sim.f
sv/tdlex_pkg.sv
sv/table_driven_lexer_dfa.sv
sv/tdlex_chk.sv
dv/table_driven_lexer_dfa_tb.sv
